// File: hw/rtl/rmpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpt_pkg
// Shared types and codes for the radix-4 mode-product transform core.
// ----------------------------------------------------------------------------
package rmpt_pkg;

  // Request function codes.
  localparam logic [1:0] FN_WR_COEF  = 2'd0;
  localparam logic [1:0] FN_WR_ENTRY = 2'd1;
  localparam logic [1:0] FN_RUN      = 2'd2;
  localparam logic [1:0] FN_READ     = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RUN,
    S_DRAIN
  } rmpt_state_t;

  // Control that travels with each multiply-accumulate step.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } rmpt_tag_t;

endpackage

// File: hw/rtl/rmpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpt_ram
// Simple dual-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module rmpt_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rmpt_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpt_mac
// Complex multiply-accumulate over four terms with rounding and saturation.
// ----------------------------------------------------------------------------
module rmpt_mac
  import rmpt_pkg::*;
#(
  parameter int PW = 32,
  parameter int AW = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  rmpt_tag_t       tag,
  input  logic [AW-1:0]   f_idx,
  input  logic [2*PW-1:0] coef_q,
  input  logic [2*PW-1:0] x_q,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [2*PW-1:0] wr_data,
  output logic            sat,
  output logic            busy
);

  localparam int FW = PW - 4;
  localparam int AC = 2 * PW + 3;
  localparam logic signed [AC-1:0] HALF = AC'(1) <<< (FW - 1);
  localparam logic signed [AC-1:0] MAXV = (AC'(1) <<< (PW - 1)) - AC'(1);
  localparam logic signed [AC-1:0] MINV = -(AC'(1) <<< (PW - 1));

  rmpt_tag_t tag1, tag2;
  logic [AW-1:0] f1, f2, f3;
  logic v3;
  logic signed [2*PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [AC-1:0] acc_re, acc_im, sum_re, sum_im, rnd_re, rnd_im;
  logic signed [PW-1:0] c_re, c_im, x_re, x_im, o_re, o_im;
  logic sat_re, sat_im;

  assign c_re = coef_q[PW-1:0];
  assign c_im = coef_q[2*PW-1:PW];
  assign x_re = x_q[PW-1:0];
  assign x_im = x_q[2*PW-1:PW];

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      v3   <= 1'b0;
    end else begin
      tag1 <= tag;
      tag2 <= tag1;
      v3   <= tag2.valid & tag2.last;
    end
  end

  // Products of the registered memory data are registered here.
  always_ff @(posedge clk) begin
    f1   <= f_idx;
    f2   <= f1;
    p_rr <= c_re * x_re;
    p_ii <= c_im * x_im;
    p_ri <= c_re * x_im;
    p_ir <= c_im * x_re;
    if (tag2.valid) begin
      acc_re <= (tag2.first ? '0 : acc_re) + sum_re;
      acc_im <= (tag2.first ? '0 : acc_im) + sum_im;
      f3     <= f2;
    end
  end

  assign sum_re = AC'(p_rr) - AC'(p_ii);
  assign sum_im = AC'(p_ri) + AC'(p_ir);

  // Round to nearest, ties up, then saturate to the part width.
  always_comb begin
    rnd_re = (acc_re + HALF) >>> FW;
    rnd_im = (acc_im + HALF) >>> FW;
    sat_re = (rnd_re > MAXV) || (rnd_re < MINV);
    sat_im = (rnd_im > MAXV) || (rnd_im < MINV);
    o_re = PW'(sat_re ? (rnd_re[AC-1] ? MINV : MAXV) : rnd_re);
    o_im = PW'(sat_im ? (rnd_im[AC-1] ? MINV : MAXV) : rnd_im);
  end

  assign wr_en   = v3;
  assign wr_addr = f3;
  assign wr_data = {o_im, o_re};
  assign sat     = v3 & (sat_re | sat_im);
  assign busy    = tag1.valid | tag2.valid | v3;

endmodule

// File: hw/rtl/radix4_mode_product_transform_core.sv
`timescale 1ns / 1ps
// Coefficient/entry writes and out-of-range requests give a result the cycle
// after acceptance; an entry read first passes the bank read and S_READ.
// A run does one bank read per MAC step. One request is worked on at a
// time; a new one is taken once the result register is free or being
// drained. Synchronous reset sets round_count to 1 and bank a current;
// memory contents are not cleared.
// ----------------------------------------------------------------------------
// radix4_mode_product_transform_core
// Applies one 4x4 complex matrix per base-4 digit to a tensor held in two
// ping-pong memory banks.
// ----------------------------------------------------------------------------
module radix4_mode_product_transform_core
  import rmpt_pkg::*;
#(
  parameter int MAX_DIGITS = 6,
  parameter int PART_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [11:0] entry_index,
  input  logic [2:0]  round_select,
  input  logic [3:0]  coef_slot,
  input  logic [31:0] value_re,
  input  logic [31:0] value_im,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_re,
  output logic [31:0] read_im,
  output logic [1:0]  status
);

  localparam int PW     = PART_WIDTH;
  localparam int AW     = 2 * MAX_DIGITS;
  localparam int DEPTH  = 1 << AW;
  localparam int CDEPTH = MAX_DIGITS * 16;
  localparam int CW     = $clog2(CDEPTH);
  localparam int DW     = $clog2(MAX_DIGITS + 1);

  rmpt_state_t state, state_next;
  logic [2:0] round_count;
  logic cur;
  logic [DW-1:0] n_digits, rnd, dpos;
  logic [AW-1:0] f_cnt, last_f, mask, src_addr, in_addr;
  logic [1:0] j_cnt, h;
  logic [DW:0] sh;
  logic [CW-1:0] coef_raddr;
  logic in_fire, idx_ok, issue, step_done, run_end, run_sat;
  logic wr_in, coef_we;
  logic [2*PW-1:0] in_data, bank_a_q, bank_b_q, coef_q, x_q;
  logic [AW-1:0] rd_addr;
  logic mac_we, mac_sat, mac_busy;
  logic [AW-1:0] mac_addr;
  logic [2*PW-1:0] mac_data;
  rmpt_tag_t tag0;
  logic out_load;
  logic [1:0] status_next;
  logic signed [PW-1:0] ld_re, ld_im;

  // Clamp the digit count into the supported range.
  always_comb begin
    if (round_count == 3'd0) begin
      n_digits = DW'(1);
    end else if (32'(round_count) > MAX_DIGITS) begin
      n_digits = DW'(MAX_DIGITS);
    end else begin
      n_digits = DW'(round_count);
    end
  end

  assign idx_ok  = (32'(entry_index) >> {n_digits, 1'b0}) == 32'd0;
  assign in_addr = AW'(entry_index);
  assign in_data = {value_im[PW-1:0], value_re[PW-1:0]};
  assign in_fire = in_valid & in_ready;

  // Address generation: replace digit dpos of the output index with j.
  assign sh         = {dpos, 1'b0};
  assign mask       = AW'(3) << sh;
  assign h          = 2'(f_cnt >> sh);
  assign src_addr   = (f_cnt & ~mask) | (AW'(j_cnt) << sh);
  assign coef_raddr = CW'({rnd, h, j_cnt});
  assign last_f     = ~({AW{1'b1}} << {n_digits, 1'b0});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && func == FN_RUN) begin
          state_next = S_RUN;
        end else if (in_fire && func == FN_READ && idx_ok) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_IDLE;
      S_RUN: begin
        if (j_cnt == 2'd3 && f_cnt == last_f) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_next = (rnd == n_digits - DW'(1)) ? S_IDLE : S_RUN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
    issue     = (state == S_RUN);
    step_done = (state == S_DRAIN) && !mac_busy;
    run_end   = step_done && (rnd == n_digits - DW'(1));
  end

  assign cfg_ready = 1'b1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      round_count <= 3'd1;
      cur         <= 1'b0;
      run_sat     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        round_count <= cfg_data;
      end
      if (step_done) begin
        cur <= ~cur;
      end
      if (in_fire && func == FN_RUN) begin
        run_sat <= 1'b0;
      end else if (mac_sat) begin
        run_sat <= 1'b1;
      end
    end
  end

  // Run counters.
  always_ff @(posedge clk) begin
    if (in_fire && func == FN_RUN) begin
      rnd   <= '0;
      dpos  <= n_digits - DW'(1);
      f_cnt <= '0;
      j_cnt <= '0;
    end else if (issue) begin
      j_cnt <= j_cnt + 2'd1;
      if (j_cnt == 2'd3) begin
        f_cnt <= f_cnt + AW'(1);
      end
    end else if (step_done) begin
      rnd   <= rnd + DW'(1);
      dpos  <= dpos - DW'(1);
      f_cnt <= '0;
      j_cnt <= '0;
    end
  end

  // Memories.
  assign wr_in   = in_fire && func == FN_WR_ENTRY && idx_ok;
  assign coef_we = in_fire && func == FN_WR_COEF && (32'(round_select) < MAX_DIGITS);
  assign rd_addr = issue ? src_addr : in_addr;

  rmpt_ram #(.DEPTH(DEPTH), .WIDTH(2 * PW)) u_bank_a (
    .clk   (clk),
    .we    ((wr_in && !cur) || (mac_we && cur)),
    .waddr (mac_we ? mac_addr : in_addr),
    .wdata (mac_we ? mac_data : in_data),
    .raddr (rd_addr),
    .rdata (bank_a_q)
  );

  rmpt_ram #(.DEPTH(DEPTH), .WIDTH(2 * PW)) u_bank_b (
    .clk   (clk),
    .we    ((wr_in && cur) || (mac_we && !cur)),
    .waddr (mac_we ? mac_addr : in_addr),
    .wdata (mac_we ? mac_data : in_data),
    .raddr (rd_addr),
    .rdata (bank_b_q)
  );

  rmpt_ram #(.DEPTH(CDEPTH), .WIDTH(2 * PW)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (CW'({round_select, coef_slot})),
    .wdata (in_data),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  assign x_q = cur ? bank_b_q : bank_a_q;

  // Multiply-accumulate datapath.
  always_comb begin
    tag0.valid = issue;
    tag0.first = (j_cnt == 2'd0);
    tag0.last  = (j_cnt == 2'd3);
  end

  rmpt_mac #(.PW(PW), .AW(AW)) u_mac (
    .clk     (clk),
    .rst     (rst),
    .tag     (tag0),
    .f_idx   (f_cnt),
    .coef_q  (coef_q),
    .x_q     (x_q),
    .wr_en   (mac_we),
    .wr_addr (mac_addr),
    .wr_data (mac_data),
    .sat     (mac_sat),
    .busy    (mac_busy)
  );

  // Result selection.
  always_comb begin
    out_load    = 1'b0;
    status_next = ST_OK;
    ld_re       = '0;
    ld_im       = '0;
    if (state == S_READ) begin
      out_load = 1'b1;
      ld_re    = x_q[PW-1:0];
      ld_im    = x_q[2*PW-1:PW];
    end else if (run_end) begin
      out_load    = 1'b1;
      status_next = run_sat ? ST_SAT : ST_OK;
    end else if (in_fire) begin
      priority case (func)
        FN_WR_COEF: begin
          out_load    = 1'b1;
          status_next = (32'(round_select) < MAX_DIGITS) ? ST_OK : ST_RANGE;
        end
        FN_WR_ENTRY: begin
          out_load    = 1'b1;
          status_next = idx_ok ? ST_OK : ST_RANGE;
        end
        FN_READ: begin
          out_load    = !idx_ok;
          status_next = ST_RANGE;
        end
        default: out_load = 1'b0;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_re <= 32'(ld_re);
      read_im <= 32'(ld_im);
      status  <= status_next;
    end
  end

endmodule

// File: tb/tb_radix4_mode_product_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix4_mode_product_transform_core
// Self-checking bench for the radix-4 mode-product transform core. Phases of
// requests load coefficients and tensor entries, run transforms and read
// entries back under several digit counts. A predictor computes each result
// exactly in fixed point, and the monitor checks results in order.
// ----------------------------------------------------------------------------
module tb_radix4_mode_product_transform_core
  import rmpt_pkg::*;
();

  localparam int DIGITS_MAX = 6;
  localparam int FRAC = 28;
  localparam int DEPTH = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 500000;

  typedef struct {
    logic [1:0]  fn;
    logic [11:0] idx;
    logic [2:0]  rsel;
    logic [3:0]  slot;
    logic [31:0] vre;
    logic [31:0] vim;
  } request_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } entry_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [11:0] entry_index = '0;
  logic [2:0]  round_select = '0;
  logic [3:0]  coef_slot = '0;
  logic [31:0] value_re = '0;
  logic [31:0] value_im = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_re;
  logic [31:0] read_im;
  logic [1:0]  status;

  // Shadow copy of the core state.
  longint bank_re[2][DEPTH];
  longint bank_im[2][DEPTH];
  longint coef_re[DIGITS_MAX*16];
  longint coef_im[DIGITS_MAX*16];
  bit     active_bank = 1'b0;
  logic [2:0] digit_reg = 3'd1;

  request_t      pending_requests[$];
  entry_result_t expected_results[$];
  request_t      current_request;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  hold_count = 0;
  bit  hold_ask = 1'b0;
  bit  quiet = 1'b0;
  int  errors = 0;
  int  idle_cycles = 0;

  radix4_mode_product_transform_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .entry_index(entry_index), .round_select(round_select),
    .coef_slot(coef_slot), .value_re(value_re), .value_im(value_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_re(read_re), .read_im(read_im), .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int effective_digits();
    if (digit_reg == 0) return 1;
    if (digit_reg > DIGITS_MAX) return DIGITS_MAX;
    return int'(digit_reg);
  endfunction

  // Adds one exact product, split into its floor part and fraction remainder.
  function automatic void add_product(longint p, inout longint hi, inout longint lo);
    longint h;
    h = p >>> FRAC;
    hi += h;
    lo += p - (h <<< FRAC);
  endfunction

  // Rounds to nearest with ties upward, then saturates to 32 bits.
  function automatic longint round_saturate(longint hi, longint lo, inout bit sat);
    longint r;
    r = hi + ((lo + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    if (r > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (r < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return r;
  endfunction

  // Applies every round of the transform; returns whether any part saturated.
  function automatic bit apply_rounds(int n);
    int total, sh, suffix, h, base, c;
    bit src, sat;
    longint rh, rl, ih, il, cr, ci, xr, xi;
    total = 1 << (2 * n);
    sat = 1'b0;
    for (int r = 0; r < n; r++) begin
      sh = 2 * (n - 1 - r);
      suffix = 1 << sh;
      src = active_bank;
      for (int f = 0; f < total; f++) begin
        h = (f >> sh) & 3;
        base = f - h * suffix;
        rh = 0; rl = 0; ih = 0; il = 0;
        for (int j = 0; j < 4; j++) begin
          c = r * 16 + h * 4 + j;
          cr = coef_re[c]; ci = coef_im[c];
          xr = bank_re[src][base + j*suffix];
          xi = bank_im[src][base + j*suffix];
          add_product(cr * xr, rh, rl);
          add_product(-(ci * xi), rh, rl);
          add_product(cr * xi, ih, il);
          add_product(ci * xr, ih, il);
        end
        bank_re[!src][f] = round_saturate(rh, rl, sat);
        bank_im[!src][f] = round_saturate(ih, il, sat);
      end
      active_bank = !active_bank;
    end
    return sat;
  endfunction

  // Updates the shadow state for one request and returns its result.
  function automatic entry_result_t predict_result(request_t q);
    entry_result_t e;
    int total;
    e.re = '0; e.im = '0; e.st = ST_OK;
    total = 1 << (2 * effective_digits());
    case (q.fn)
      FN_WR_COEF: begin
        if (q.rsel < DIGITS_MAX) begin
          coef_re[q.rsel*16 + q.slot] = longint'(signed'(q.vre));
          coef_im[q.rsel*16 + q.slot] = longint'(signed'(q.vim));
        end else begin
          e.st = ST_RANGE;
        end
      end
      FN_WR_ENTRY: begin
        if (q.idx < total) begin
          bank_re[active_bank][q.idx] = longint'(signed'(q.vre));
          bank_im[active_bank][q.idx] = longint'(signed'(q.vim));
        end else begin
          e.st = ST_RANGE;
        end
      end
      FN_RUN: begin
        e.st = apply_rounds(effective_digits()) ? ST_SAT : ST_OK;
      end
      default: begin
        if (q.idx < total) begin
          e.re = bank_re[active_bank][q.idx][31:0];
          e.im = bank_im[active_bank][q.idx][31:0];
        end else begin
          e.st = ST_RANGE;
        end
      end
    endcase
    return e;
  endfunction

  // Request driver: presents queued requests and predicts each accepted one.
  always @(posedge clk) begin : drive_requests
    logic v_next;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      v_next = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(current_request));
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() > 0) begin
          current_request = pending_requests.pop_front();
          func <= current_request.fn;
          entry_index <= current_request.idx;
          round_select <= current_request.rsel;
          coef_slot <= current_request.slot;
          value_re <= current_request.vre;
          value_im <= current_request.vim;
          v_next = 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end
      end
      in_valid <= v_next;
    end
  end

  // Result monitor: drives out_ready and checks each result in order.
  always @(posedge clk) begin : check_results
    entry_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: re %h im %h status %0d",
                 read_re, read_im, status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (read_re !== e.re) begin
            $error("read_re expected %h actual %h", e.re, read_re);
            errors++;
          end
          if (read_im !== e.im) begin
            $error("read_im expected %h actual %h", e.im, read_im);
            errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            errors++;
          end
        end
      end
      if (hold_ask && hold_count < HOLD_CYCLES) begin
        hold_count++;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 6) == 0) recv_stall = $urandom_range(1, 4);
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_radix4_mode_product_transform_core NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_part(bit full);
    if (full) return $urandom;
    return 32'($urandom_range(0, 32'h07FF_FFFF)) - 32'h0400_0000;
  endfunction

  task automatic queue_request(logic [1:0] fn, logic [11:0] idx, logic [2:0] rsel,
                               logic [3:0] slot, logic [31:0] vre, logic [31:0] vim);
    request_t q;
    q.fn = fn; q.idx = idx; q.rsel = rsel; q.slot = slot; q.vre = vre; q.vim = vim;
    pending_requests.push_back(q);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_digits(logic [2:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    digit_reg = v;
  endtask

  // Loads all coefficients used by a run and every entry of the current bank.
  task automatic load_operands(int n, bit full);
    for (int r = 0; r < n; r++)
      for (int s = 0; s < 16; s++)
        queue_request(FN_WR_COEF, 12'($urandom), 3'(r), 4'(s), rand_part(full),
                      rand_part(full));
    for (int i = 0; i < (1 << (2*n)); i++)
      queue_request(FN_WR_ENTRY, 12'(i), 3'($urandom), 4'($urandom), rand_part(full),
                    rand_part(full));
  endtask

  // Random traffic; in-range reads only touch loaded entries.
  task automatic queue_random(int count, int n, bit full);
    int total, k;
    total = 1 << (2*n);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25)
        queue_request(FN_WR_ENTRY, 12'($urandom_range(0, total-1)), 3'($urandom),
                      4'($urandom), rand_part(full), rand_part(full));
      else if (k < 35)
        queue_request(FN_WR_ENTRY, 12'($urandom), 3'($urandom), 4'($urandom),
                      rand_part(full), rand_part(full));
      else if (k < 55)
        queue_request(FN_READ, 12'($urandom_range(0, total-1)), 3'($urandom),
                      4'($urandom), $urandom, $urandom);
      else if (k < 62)
        queue_request(FN_READ, 12'($urandom), 3'($urandom), 4'($urandom),
                      $urandom, $urandom);
      else if (k < 72)
        queue_request(FN_WR_COEF, 12'($urandom), 3'($urandom_range(0, n-1)),
                      4'($urandom), rand_part(full), rand_part(full));
      else if (k < 80)
        queue_request(FN_WR_COEF, 12'($urandom), 3'($urandom_range(0, 7)),
                      4'($urandom), $urandom, $urandom);
      else if (k < 90 && n <= 3)
        queue_request(FN_RUN, 12'($urandom), 3'($urandom), 4'($urandom),
                      $urandom, $urandom);
      else
        queue_request(FN_READ, 12'($urandom_range(0, total-1)), 3'($urandom),
                      4'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic run_phase(logic [2:0] digits, bit full, int count);
    int n;
    wait_drained();
    write_digits(digits);
    n = effective_digits();
    load_operands(n, full);
    queue_random(count, n, full);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at one digit: extremes, range errors, a saturating run.
    write_digits(3'd1);
    load_operands(1, 1'b1);
    queue_request(FN_WR_COEF, 12'hFFF, 3'd0, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(FN_WR_COEF, 12'h000, 3'd0, 4'd15, 32'h8000_0000, 32'h8000_0000);
    queue_request(FN_WR_ENTRY, 12'd0, 3'd7, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(FN_WR_ENTRY, 12'd3, 3'd0, 4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(FN_READ, 12'd0, 3'd0, 4'd0, 32'h0, 32'h0);
    queue_request(FN_READ, 12'd3, 3'd7, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(FN_WR_ENTRY, 12'd4, 3'd0, 4'd0, 32'h1234_5678, 32'h8765_4321);
    queue_request(FN_WR_ENTRY, 12'hFFF, 3'd0, 4'd0, 32'h1, 32'h1);
    queue_request(FN_READ, 12'hFFF, 3'd0, 4'd0, 32'h0, 32'h0);
    queue_request(FN_WR_COEF, 12'd0, 3'd6, 4'd3, 32'h1, 32'h1);
    queue_request(FN_WR_COEF, 12'd0, 3'd7, 4'd9, 32'h1, 32'h1);
    queue_request(FN_RUN, 12'd0, 3'd0, 4'd0, 32'h0, 32'h0);
    for (int i = 0; i < 4; i++)
      queue_request(FN_READ, 12'(i), 3'd0, 4'd0, 32'h0, 32'h0);
    queue_random(30, 1, 1'b1);

    // A digit count of zero acts as one.
    run_phase(3'd0, 1'b0, 20);

    // Long receiver hold while requests keep coming.
    wait_drained();
    write_digits(3'd2);
    hold_ask = 1'b1;
    load_operands(2, 1'b0);
    queue_random(60, 2, 1'b0);

    run_phase(3'd3, 1'b1, 40);

    // Digit count above the maximum acts as the maximum: the top entries are in range.
    wait_drained();
    write_digits(3'd7);
    for (int i = 0; i < 8; i++)
      queue_request(FN_WR_ENTRY, 12'(4088 + i), 3'd0, 4'd0, rand_part(1'b1),
                    rand_part(1'b1));
    for (int i = 0; i < 8; i++)
      queue_request(FN_READ, 12'(4088 + i), 3'd0, 4'd0, 32'h0, 32'h0);
    queue_request(FN_WR_COEF, 12'd0, 3'd5, 4'd15, 32'h1, 32'h1);
    queue_request(FN_WR_COEF, 12'd0, 3'd6, 4'd0, 32'h1, 32'h1);

    // Final stretch with no idling on either side.
    wait_drained();
    quiet = 1'b1;
    write_digits(3'd2);
    load_operands(2, 1'b1);
    queue_random(30, 2, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_radix4_mode_product_transform_core OK");
    end else begin
      $display("tb_radix4_mode_product_transform_core NOT OK");
    end
    $finish;
  end

endmodule
